[rtl/tile_background_pixel_fetch_assert.svh]
// assertion macros for the tile background pixel fetch block
`ifndef TILE_BACKGROUND_PIXEL_FETCH_ASSERT_SVH
`define TILE_BACKGROUND_PIXEL_FETCH_ASSERT_SVH
`ifndef SYNTHESIS
`define TBPF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbpf: implication check failed");
`define TBPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error("tbpf: sequence check failed");
`else
`define TBPF_ASSERT_IMP(label, clk, rst, ante, cons)
`define TBPF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/tbpf_pkg.sv]
// shared types and constants of the tile background pixel fetch block
package tbpf_pkg;

  localparam int RAM_BYTES_DEFAULT = 16384;
  localparam int ADDR_W = 14;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam int JOB_QUEUE_DEPTH = 4;
  localparam int RES_QUEUE_DEPTH = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NAME_BASE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BASE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_BASE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HSCROLL = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_VSCROLL = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP_LOCK = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_LOCK = 3'd7;

  localparam logic [3:0] MODE_TWO_COLOR = 4'd0;
  localparam logic [3:0] MODE_TWO_COLOR_SPLIT = 4'd2;
  localparam logic [3:0] MODE_TILE_8 = 4'd8;
  localparam logic [3:0] MODE_TILE_10 = 4'd10;
  localparam logic [3:0] MODE_TILE_224 = 4'd11;
  localparam logic [3:0] MODE_TILE_12 = 4'd12;
  localparam logic [3:0] MODE_TILE_240 = 4'd14;
  localparam logic [3:0] MODE_TILE_15 = 4'd15;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [13:0] ram_address;
    logic [7:0]  ram_data;
    logic [7:0]  pixel_column;
    logic [8:0]  pixel_line;
  } item_t;

  typedef struct packed {
    logic [3:0] pixel_color;
    logic       palette_select;
    logic       front_priority;
  } result_t;

  typedef struct packed {
    logic [3:0] display_mode;
    logic [3:0] name_table_base;
    logic [2:0] pattern_table_base;
    logic [7:0] color_table_base;
    logic [7:0] horizontal_scroll;
    logic [7:0] vertical_scroll;
    logic       top_rows_scroll_lock;
    logic       right_columns_scroll_lock;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_ZERO,
    KIND_TWO,
    KIND_TILE
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic [2:0]        col3;
    logic [2:0]        line3;
    logic              split;
    logic [2:0]        pat_hi;
    logic [2:0]        col_hi;
  } job_t;

endpackage

[rtl/tile_background_pixel_fetch.sv]
// top level of the tile background pixel fetch block
//
//  port group                 direction  handshake
//  item / push / full         in         word taken when push and not full
//  result / empty / pop       out        word taken when pop and not empty
//  wr_en / wr_index / wr_data in         register written when wr_en
//
// a ram write, and a pixel with a zero result, are done in the idle state of the fetch
// sequencer; a tile pixel makes six reads through the single video ram port and then
// emits the word, and a two-color pixel reads its name, pattern and color bytes in turn
// the job queue holds 4 words and the result queue 2; input stalls only when
// the job queue is full, and the sequencer waits to start a pixel while the result queue is full
// synchronous reset clears the registers and both queues; video ram is not cleared
module tile_background_pixel_fetch #(
  parameter int RAM_BYTES = tbpf_pkg::RAM_BYTES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  tbpf_pkg::item_t                  item,
  output logic                             empty,
  input  logic                             pop,
  output tbpf_pkg::result_t                result,
  input  logic                             wr_en,
  input  logic [tbpf_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [tbpf_pkg::CFG_DATA_W-1:0]  wr_data
);

  tbpf_pkg::cfg_t cfg;
  tbpf_pkg::job_t job_in;
  tbpf_pkg::job_t job_out;
  logic job_empty;
  logic job_pop;
  tbpf_pkg::result_t res;
  logic res_push;
  logic res_full;

  tbpf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .item     (item),
    .cfg      (cfg),
    .job      (job_in)
  );

  tbpf_fifo #(
    .WIDTH ($bits(tbpf_pkg::job_t)),
    .DEPTH (tbpf_pkg::JOB_QUEUE_DEPTH)
  ) u_job_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (job_in),
    .full  (full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  tbpf_back #(
    .RAM_BYTES (RAM_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job       (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .res       (res),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  tbpf_fifo #(
    .WIDTH ($bits(tbpf_pkg::result_t)),
    .DEPTH (tbpf_pkg::RES_QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

[rtl/tbpf_fifo.sv]
// small synchronous word queue
module tbpf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] wr_ptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push & ~full;
  assign do_pop = pop & ~empty;
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/tbpf_front.sv]
// register file and classifier: turns input words into fetch jobs
module tbpf_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [tbpf_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  logic [tbpf_pkg::CFG_DATA_W-1:0]     wr_data,
  input  tbpf_pkg::item_t                     item,
  output tbpf_pkg::cfg_t                      cfg,
  output tbpf_pkg::job_t                      job
);

  localparam logic [8:0] LOCK_LINES = 9'd16;
  localparam logic [7:0] LOCK_COLUMN = 8'd191;
  localparam logic [8:0] WRAP_LINE = 9'd224;

  logic [7:0] col;
  logic [8:0] line;
  logic       fine_mask;
  logic [7:0] col_s;
  logic [8:0] line_v;
  logic [8:0] line_192;
  logic [8:0] line_tall;
  logic       b11;
  logic       b12;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        tbpf_pkg::REG_DISPLAY_MODE: cfg.display_mode <= wr_data[3:0];
        tbpf_pkg::REG_NAME_BASE: cfg.name_table_base <= wr_data[3:0];
        tbpf_pkg::REG_PATTERN_BASE: cfg.pattern_table_base <= wr_data[2:0];
        tbpf_pkg::REG_COLOR_BASE: cfg.color_table_base <= wr_data;
        tbpf_pkg::REG_HSCROLL: cfg.horizontal_scroll <= wr_data;
        tbpf_pkg::REG_VSCROLL: cfg.vertical_scroll <= wr_data;
        tbpf_pkg::REG_TOP_LOCK: cfg.top_rows_scroll_lock <= wr_data[0];
        tbpf_pkg::REG_RIGHT_LOCK: cfg.right_columns_scroll_lock <= wr_data[0];
        default: cfg <= cfg;
      endcase
    end
  end

  assign col = item.pixel_column;
  assign line = item.pixel_line;

  // scrolled position for the tile modes
  assign fine_mask = (col < {5'b0, cfg.horizontal_scroll[2:0]});
  assign col_s = (cfg.top_rows_scroll_lock && line < LOCK_LINES) ? col
               : col - cfg.horizontal_scroll;
  assign line_v = (!cfg.right_columns_scroll_lock || col_s <= LOCK_COLUMN)
                ? line + {1'b0, cfg.vertical_scroll} : line;
  assign line_192 = (line_v >= WRAP_LINE) ? line_v - WRAP_LINE : line_v;
  assign line_tall = line_v + WRAP_LINE;

  // mode 2 thirds
  assign b11 = (line[8:6] == 3'd1);
  assign b12 = (line[8:6] == 3'd2);

  always_comb begin
    job = '0;
    job.kind = tbpf_pkg::KIND_ZERO;
    job.addr = item.ram_address;
    job.data = item.ram_data;
    if (item.opcode == tbpf_pkg::OP_WRITE) begin
      job.kind = tbpf_pkg::KIND_WRITE;
    end else begin
      unique case (cfg.display_mode) inside
        tbpf_pkg::MODE_TWO_COLOR, tbpf_pkg::MODE_TWO_COLOR_SPLIT: begin
          job.kind = tbpf_pkg::KIND_TWO;
          job.addr = {cfg.name_table_base, line[7:3], col[7:3]};
          job.col3 = col[2:0];
          job.line3 = line[2:0];
          if (cfg.display_mode == tbpf_pkg::MODE_TWO_COLOR_SPLIT) begin
            job.split = 1'b1;
            job.pat_hi = {cfg.pattern_table_base[2], b12 & cfg.pattern_table_base[1],
                          b11 & cfg.pattern_table_base[0]};
            job.col_hi = {cfg.color_table_base[7], b12 & cfg.pattern_table_base[1],
                          b11 & cfg.pattern_table_base[0]};
          end else begin
            job.pat_hi = cfg.pattern_table_base;
          end
        end
        tbpf_pkg::MODE_TILE_8, tbpf_pkg::MODE_TILE_10, tbpf_pkg::MODE_TILE_12,
        tbpf_pkg::MODE_TILE_15: begin
          if (!fine_mask) begin
            job.kind = tbpf_pkg::KIND_TILE;
            job.addr = {cfg.name_table_base[3:1], line_192[7:3], col_s[7:3], 1'b0};
            job.col3 = col_s[2:0];
            job.line3 = line_192[2:0];
          end
        end
        tbpf_pkg::MODE_TILE_224, tbpf_pkg::MODE_TILE_240: begin
          if (!fine_mask) begin
            job.kind = tbpf_pkg::KIND_TILE;
            job.addr = {cfg.name_table_base[3:2], line_tall[8:3], col_s[7:3], 1'b0};
            job.col3 = col_s[2:0];
            job.line3 = line_tall[2:0];
          end
        end
        default: job.kind = tbpf_pkg::KIND_ZERO;
      endcase
    end
  end

endmodule

[rtl/tbpf_back.sv]
// video ram and fetch sequencer: runs jobs and produces pixel words
`include "tile_background_pixel_fetch_assert.svh"

module tbpf_back #(
  parameter int RAM_BYTES = tbpf_pkg::RAM_BYTES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  tbpf_pkg::cfg_t   cfg,
  input  tbpf_pkg::job_t   job,
  input  logic             job_empty,
  output logic             job_pop,
  output tbpf_pkg::result_t res,
  output logic             res_push,
  input  logic             res_full
);

  localparam int AW = $clog2(RAM_BYTES);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_LO,
    ST_T_HI,
    ST_T_P0,
    ST_T_P1,
    ST_T_P2,
    ST_T_P3,
    ST_C_NAME,
    ST_C_PAT,
    ST_C_COL
  } state_t;

  logic [7:0] vram [RAM_BYTES];
  logic [7:0] rdata;
  logic [tbpf_pkg::ADDR_W-1:0] raddr;
  logic mem_we;

  state_t state;
  tbpf_pkg::job_t cur;
  logic [7:0] lo_byte;
  logic [7:0] tile;
  logic [tbpf_pkg::ADDR_W-1:0] pat_base;
  logic [2:0] colx;
  logic palette;
  logic priority_bit;
  logic [2:0] acc;
  logic pat_bit;

  logic start;
  logic [15:0] entry;
  logic [2:0] colx_now;
  logic [2:0] linex_now;
  logic [tbpf_pkg::ADDR_W-1:0] pat_now;
  logic tile_bit;
  logic [3:0] tile_color;
  logic [tbpf_pkg::ADDR_W-1:0] two_pat_addr;
  logic [tbpf_pkg::ADDR_W-1:0] two_col_addr;

  assign start = (state == ST_IDLE) && !job_empty
               && ((job.kind == tbpf_pkg::KIND_WRITE) || !res_full);
  assign job_pop = start;
  assign mem_we = start && (job.kind == tbpf_pkg::KIND_WRITE);

  assign entry = {rdata, lo_byte};
  assign colx_now = cur.col3 ^ {3{entry[9]}};
  assign linex_now = cur.line3 ^ {3{entry[10]}};
  assign pat_now = {entry[8:0], linex_now, 2'b00};
  assign tile_bit = rdata[~colx];
  assign tile_color = {tile_bit, acc};

  assign two_pat_addr = {cur.pat_hi, rdata, cur.line3};
  assign two_col_addr = cur.split ? {cur.col_hi, tile, cur.line3}
                      : {cfg.color_table_base, 1'b0, tile[7:3]};

  always_comb begin
    unique case (state)
      ST_IDLE: raddr = job.addr;
      ST_T_LO: raddr = {cur.addr[tbpf_pkg::ADDR_W-1:1], 1'b1};
      ST_T_HI: raddr = pat_now;
      ST_T_P0: raddr = {pat_base[tbpf_pkg::ADDR_W-1:2], 2'd1};
      ST_T_P1: raddr = {pat_base[tbpf_pkg::ADDR_W-1:2], 2'd2};
      ST_T_P2: raddr = {pat_base[tbpf_pkg::ADDR_W-1:2], 2'd3};
      ST_C_NAME: raddr = two_pat_addr;
      ST_C_PAT: raddr = two_col_addr;
      default: raddr = cur.addr;
    endcase
  end

  always_comb begin
    res = '0;
    res_push = 1'b0;
    unique case (state)
      ST_IDLE: res_push = start && (job.kind == tbpf_pkg::KIND_ZERO);
      ST_T_P3: begin
        res_push = 1'b1;
        res.pixel_color = tile_color;
        res.palette_select = palette;
        res.front_priority = priority_bit & (tile_color != 4'd0);
      end
      ST_C_COL: begin
        res_push = 1'b1;
        res.pixel_color = pat_bit ? rdata[7:4] : rdata[3:0];
      end
      default: res_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vram[job.addr[AW-1:0]] <= job.data;
    end
    rdata <= vram[raddr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cur <= job;
            if (job.kind == tbpf_pkg::KIND_TILE) begin
              state <= ST_T_LO;
            end else if (job.kind == tbpf_pkg::KIND_TWO) begin
              state <= ST_C_NAME;
            end
          end
        end
        ST_T_LO: begin
          lo_byte <= rdata;
          state <= ST_T_HI;
        end
        ST_T_HI: begin
          pat_base <= pat_now;
          colx <= colx_now;
          palette <= entry[11];
          priority_bit <= entry[12];
          state <= ST_T_P0;
        end
        ST_T_P0: begin
          acc <= {tile_bit, acc[2:1]};
          state <= ST_T_P1;
        end
        ST_T_P1: begin
          acc <= {tile_bit, acc[2:1]};
          state <= ST_T_P2;
        end
        ST_T_P2: begin
          acc <= {tile_bit, acc[2:1]};
          state <= ST_T_P3;
        end
        ST_T_P3: state <= ST_IDLE;
        ST_C_NAME: begin
          tile <= rdata;
          state <= ST_C_PAT;
        end
        ST_C_PAT: begin
          pat_bit <= rdata[~cur.col3];
          state <= ST_C_COL;
        end
        ST_C_COL: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  `TBPF_ASSERT_IMP(a_res_room, clk, rst, res_push, !res_full)
  `TBPF_ASSERT_NEXT(a_tile_latency, clk, rst, job_pop && job.kind == tbpf_pkg::KIND_TILE, ##5 res_push)
  `TBPF_ASSERT_NEXT(a_two_latency, clk, rst, job_pop && job.kind == tbpf_pkg::KIND_TWO, ##2 res_push)

endmodule

[tb/sv/tb.sv]
// testbench for tile_background_pixel_fetch: ram loads and renders checked against a predictor
module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  tbpf_pkg::item_t in_word = '0;
  logic empty;
  logic pop = 1'b0;
  tbpf_pkg::result_t out_word;
  logic wr_en = 1'b0;
  logic [tbpf_pkg::CFG_INDEX_W-1:0] wr_index = '0;
  logic [tbpf_pkg::CFG_DATA_W-1:0] wr_data = '0;

  tile_background_pixel_fetch i_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(in_word),
    .empty(empty),
    .pop(pop),
    .result(out_word),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

  tbpf_pkg::cfg_t mdl_cfg = '0;
  logic [7:0] vram_model [tbpf_pkg::RAM_BYTES_DEFAULT];
  logic [7:0] plan_ram [tbpf_pkg::RAM_BYTES_DEFAULT];
  bit plan_known [tbpf_pkg::RAM_BYTES_DEFAULT];
  bit gap_found;
  logic [13:0] gap_addr;
  logic [13:0] last_read;

  tbpf_pkg::item_t pending_words [$];
  tbpf_pkg::result_t pixel_due [$];
  int queued_cnt = 0;
  int accepted_cnt = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cyc = 0;
  bit in_taken = 1'b0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  wire calm = (cyc % 8000) >= 6000;

  initial begin
    for (int a = 0; a < tbpf_pkg::RAM_BYTES_DEFAULT; a++) begin
      vram_model[a] = '0;
      plan_ram[a] = '0;
      plan_known[a] = 1'b0;
    end
  end

  function automatic logic [7:0] vram_byte(bit shadow, logic [13:0] a);
    if (shadow) begin
      if (!plan_known[a] && !gap_found) begin
        gap_found = 1'b1;
        gap_addr = a;
      end
      last_read = a;
      return plan_ram[a];
    end
    return vram_model[a];
  endfunction

  function automatic logic [3:0] two_color_pixel(bit shadow, logic [7:0] col, logic [8:0] line,
                                                 bit split);
    logic [13:0] pat_a, clr_a;
    logic [7:0] tile, clr, pat;
    tile = vram_byte(shadow, {mdl_cfg.name_table_base, line[7:3], col[7:3]});
    if (!split) begin
      pat_a = {mdl_cfg.pattern_table_base, tile, line[2:0]};
      clr_a = {mdl_cfg.color_table_base, 1'b0, tile[7:3]};
    end else begin
      pat_a = {3'b000, tile, line[2:0]};
      if (line >= 64 && line <= 127) pat_a[11] = mdl_cfg.pattern_table_base[0];
      if (line >= 128 && line <= 191) pat_a[12] = mdl_cfg.pattern_table_base[1];
      clr_a = pat_a;
      clr_a[13] = mdl_cfg.color_table_base[7];
      pat_a[13] = mdl_cfg.pattern_table_base[2];
    end
    clr = vram_byte(shadow, clr_a);
    pat = vram_byte(shadow, pat_a);
    return pat[3'd7 - col[2:0]] ? clr[7:4] : clr[3:0];
  endfunction

  function automatic tbpf_pkg::result_t tile_pixel(bit shadow, logic [7:0] col, logic [8:0] line,
                                                   bit tall);
    tbpf_pkg::result_t r;
    logic [7:0] c;
    logic [8:0] l;
    logic [13:0] name_a, pat_a;
    logic [15:0] entry;
    logic [7:0] plane;
    logic [2:0] sh;
    r = '0;
    if (col < {5'b0, mdl_cfg.horizontal_scroll[2:0]}) return r;
    c = col;
    l = line;
    if (!mdl_cfg.top_rows_scroll_lock || line >= 16) c = col - mdl_cfg.horizontal_scroll;
    if (!mdl_cfg.right_columns_scroll_lock || c <= 191)
      l = line + {1'b0, mdl_cfg.vertical_scroll};
    if (!tall) begin
      if (l >= 224) l = l - 9'd224;
      name_a = {mdl_cfg.name_table_base[3:1], l[7:3], c[7:3], 1'b0};
    end else begin
      l = l + 9'd224;
      name_a = {mdl_cfg.name_table_base[3:2], l[8:3], c[7:3], 1'b0};
    end
    entry = {vram_byte(shadow, name_a | 14'd1), vram_byte(shadow, name_a)};
    if (entry[9]) c[2:0] = ~c[2:0];
    if (entry[10]) l[2:0] = ~l[2:0];
    pat_a = {entry[8:0], l[2:0], 2'b00};
    sh = 3'd7 - c[2:0];
    for (int p = 0; p < 4; p++) begin
      plane = vram_byte(shadow, pat_a | 14'(p));
      r.pixel_color[p] = plane[sh];
    end
    r.palette_select = entry[11];
    r.front_priority = entry[12] && (r.pixel_color != 4'd0);
    return r;
  endfunction

  function automatic tbpf_pkg::result_t fetch_pixel(bit shadow, logic [7:0] col,
                                                    logic [8:0] line);
    tbpf_pkg::result_t r;
    r = '0;
    case (mdl_cfg.display_mode)
      tbpf_pkg::MODE_TWO_COLOR: r.pixel_color = two_color_pixel(shadow, col, line, 1'b0);
      tbpf_pkg::MODE_TWO_COLOR_SPLIT: r.pixel_color = two_color_pixel(shadow, col, line, 1'b1);
      tbpf_pkg::MODE_TILE_8, tbpf_pkg::MODE_TILE_10, tbpf_pkg::MODE_TILE_12,
      tbpf_pkg::MODE_TILE_15:
        r = tile_pixel(shadow, col, line, 1'b0);
      tbpf_pkg::MODE_TILE_224, tbpf_pkg::MODE_TILE_240: r = tile_pixel(shadow, col, line, 1'b1);
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic queue_write(logic [13:0] addr, logic [7:0] data);
    tbpf_pkg::item_t w;
    w.opcode = tbpf_pkg::OP_WRITE;
    w.ram_address = addr;
    w.ram_data = data;
    w.pixel_column = 8'($urandom);
    w.pixel_line = 9'($urandom);
    plan_ram[addr] = data;
    plan_known[addr] = 1'b1;
    pending_words.push_back(w);
    queued_cnt++;
  endtask

  // load any byte the pixel would read before it has been written
  task automatic queue_render(logic [7:0] col, logic [8:0] line);
    tbpf_pkg::item_t w;
    for (int n = 0; n < 8; n++) begin
      gap_found = 1'b0;
      void'(fetch_pixel(1'b1, col, line));
      if (!gap_found) break;
      queue_write(gap_addr, 8'($urandom));
    end
    w.opcode = tbpf_pkg::OP_RENDER;
    w.ram_address = 14'($urandom);
    w.ram_data = 8'($urandom);
    w.pixel_column = col;
    w.pixel_line = line;
    pending_words.push_back(w);
    queued_cnt++;
  endtask

  task automatic apply_settings(tbpf_pkg::cfg_t c);
    logic [7:0] v, m;
    mdl_cfg = c;
    for (int i = 0; i < 8; i++) begin
      v = '0;
      m = 8'hff;
      case (i[tbpf_pkg::CFG_INDEX_W-1:0])
        tbpf_pkg::REG_DISPLAY_MODE: begin v = 8'(c.display_mode); m = 8'h0f; end
        tbpf_pkg::REG_NAME_BASE: begin v = 8'(c.name_table_base); m = 8'h0f; end
        tbpf_pkg::REG_PATTERN_BASE: begin v = 8'(c.pattern_table_base); m = 8'h07; end
        tbpf_pkg::REG_COLOR_BASE: v = c.color_table_base;
        tbpf_pkg::REG_HSCROLL: v = c.horizontal_scroll;
        tbpf_pkg::REG_VSCROLL: v = c.vertical_scroll;
        tbpf_pkg::REG_TOP_LOCK: begin v = 8'(c.top_rows_scroll_lock); m = 8'h01; end
        tbpf_pkg::REG_RIGHT_LOCK: begin v = 8'(c.right_columns_scroll_lock); m = 8'h01; end
        default: v = '0;
      endcase
      @(negedge clk);
      wr_en <= 1'b1;
      wr_index <= i[tbpf_pkg::CFG_INDEX_W-1:0];
      wr_data <= v | (8'($urandom) & ~m);
    end
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  function automatic tbpf_pkg::cfg_t random_settings();
    tbpf_pkg::cfg_t c;
    logic [3:0] used [8];
    used = '{tbpf_pkg::MODE_TWO_COLOR, tbpf_pkg::MODE_TWO_COLOR_SPLIT, tbpf_pkg::MODE_TILE_8,
             tbpf_pkg::MODE_TILE_10, tbpf_pkg::MODE_TILE_224, tbpf_pkg::MODE_TILE_12,
             tbpf_pkg::MODE_TILE_240, tbpf_pkg::MODE_TILE_15};
    c.display_mode = ($urandom_range(99) < 75) ? used[$urandom_range(7)] : 4'($urandom);
    c.name_table_base = 4'($urandom);
    c.pattern_table_base = 3'($urandom);
    c.color_table_base = 8'($urandom);
    c.horizontal_scroll = 8'($urandom);
    c.vertical_scroll = 8'($urandom);
    c.top_rows_scroll_lock = 1'($urandom);
    c.right_columns_scroll_lock = 1'($urandom);
    return c;
  endfunction

  task automatic wait_drained();
    do @(negedge clk); while (accepted_cnt != queued_cnt || pixel_due.size() != 0);
    repeat (60) @(negedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || in_taken) begin
      if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 25)) begin
        in_word <= pending_words.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 100 && pending_words.size() > 40) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      pop <= 1'b0;
    end else begin
      pop <= calm || ($urandom_range(99) >= 25);
    end
  end

  // monitor
  always @(posedge clk) begin
    tbpf_pkg::result_t want;
    cyc++;
    if (pop && !empty) begin
      results_seen++;
      if (pixel_due.size() == 0) begin
        $display("%0t unexpected result word: expected none, got %h", $time, out_word);
        mismatches++;
      end else begin
        want = pixel_due.pop_front();
        if (out_word.pixel_color !== want.pixel_color) begin
          $display("%0t pixel_color: expected %0d, got %0d", $time, want.pixel_color,
                   out_word.pixel_color);
          mismatches++;
        end
        if (out_word.palette_select !== want.palette_select) begin
          $display("%0t palette_select: expected %0d, got %0d", $time, want.palette_select,
                   out_word.palette_select);
          mismatches++;
        end
        if (out_word.front_priority !== want.front_priority) begin
          $display("%0t front_priority: expected %0d, got %0d", $time, want.front_priority,
                   out_word.front_priority);
          mismatches++;
        end
      end
    end
    in_taken = push && !full;
    if (in_taken) begin
      accepted_cnt++;
      if (in_word.opcode == tbpf_pkg::OP_WRITE) vram_model[in_word.ram_address] = in_word.ram_data;
      else pixel_due.push_back(fetch_pixel(1'b0, in_word.pixel_column, in_word.pixel_line));
    end
  end

  initial begin
    tbpf_pkg::cfg_t c;
    int roll;
    logic [7:0] col;
    logic [8:0] line;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 19; ph++) begin
      c = '0;
      case (ph)
        0: ;
        1: begin
          c.display_mode = tbpf_pkg::MODE_TWO_COLOR_SPLIT;
          c.name_table_base = 4'hf;
          c.pattern_table_base = 3'h7;
          c.color_table_base = 8'hff;
        end
        2: begin
          c.display_mode = tbpf_pkg::MODE_TILE_8;
          c.name_table_base = 4'hf;
          c.horizontal_scroll = 8'hff;
          c.vertical_scroll = 8'hff;
          c.top_rows_scroll_lock = 1'b1;
          c.right_columns_scroll_lock = 1'b1;
        end
        3: c.display_mode = tbpf_pkg::MODE_TILE_224;
        4: begin
          c.display_mode = tbpf_pkg::MODE_TILE_240;
          c.horizontal_scroll = 8'd16;
          c.vertical_scroll = 8'd40;
        end
        5: c.display_mode = 4'd5;
        6: c = '1;
        7: c.display_mode = tbpf_pkg::MODE_TILE_8;
        default: c = random_settings();
      endcase
      apply_settings(c);
      case (ph)
        0: begin
          queue_write(14'h0000, 8'hff);
          queue_write(14'h3fff, 8'h00);
          queue_render(8'd0, 9'd0);
          queue_render(8'd255, 9'd511);
        end
        1: begin
          queue_render(8'd17, 9'd70);
          queue_render(8'd255, 9'd130);
          queue_render(8'd3, 9'd200);
        end
        2: begin
          queue_render(8'd3, 9'd40);
          queue_render(8'd255, 9'd10);
          queue_render(8'd200, 9'd300);
          queue_render(8'd100, 9'd100);
        end
        3: begin
          queue_render(8'd0, 9'd0);
          queue_render(8'd255, 9'd511);
        end
        4: queue_render(8'd128, 9'd300);
        5: queue_render(8'd10, 9'd10);
        default: begin
          while (queued_cnt < (ph - 5) * 146) begin
            roll = $urandom_range(99);
            if (roll < 12) begin
              queue_write(14'($urandom), 8'($urandom));
            end else if (roll < 25) begin
              queue_write(last_read, 8'($urandom));
            end else begin
              roll = $urandom_range(99);
              col = (roll < 15) ? 8'($urandom_range(7)) : 8'($urandom);
              roll = $urandom_range(99);
              if (roll < 15) line = 9'($urandom_range(15));
              else if (roll < 60) line = 9'($urandom_range(255));
              else line = 9'($urandom);
              queue_render(col, line);
            end
          end
        end
      endcase
      wait_drained();
    end
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

[tile_background_pixel_fetch.f]
+incdir+rtl
rtl/tbpf_pkg.sv
rtl/tbpf_fifo.sv
rtl/tbpf_front.sv
rtl/tbpf_back.sv
rtl/tile_background_pixel_fetch.sv
tb/sv/tb.sv
